// ===== rtl/core/brr_pkg.sv =====
// ----------------------------------------------------------------------------
// BRR decoder package
// Shared types and constants for the bit-rate-reduction block decoder.
// ----------------------------------------------------------------------------
package brr_pkg;

    localparam int SAMPLE_W = 16;

    // Prediction filter codes from header bits 3..2.
    localparam logic [1:0] FILT_NONE = 2'd0;
    localparam logic [1:0] FILT_ONE  = 2'd1;
    localparam logic [1:0] FILT_TWO  = 2'd2;
    localparam logic [1:0] FILT_THR  = 2'd3;

    // Settings latched from the most recent block header.
    typedef struct packed {
        logic [3:0] shift;
        logic [1:0] filter;
        logic       end_bit;
    } t_brr_hdr;

endpackage

// ===== rtl/core/brr_sample_calc.sv =====
// ----------------------------------------------------------------------------
// BRR sample calculator
// Forms one decoded sample from a nibble, the header settings and the history.
// ----------------------------------------------------------------------------
module brr_sample_calc
    import brr_pkg::*;
(
    input  logic [3:0]          i_nibble,
    input  t_brr_hdr            i_hdr,
    input  logic [SAMPLE_W-1:0] i_prev_one,
    input  logic [SAMPLE_W-1:0] i_prev_two,
    output logic [SAMPLE_W-1:0] o_sample
);

    localparam int ACC_W = 25;

    localparam logic signed [ACC_W-1:0] K_60  = 25'sd60;
    localparam logic signed [ACC_W-1:0] K_122 = 25'sd122;
    localparam logic signed [ACC_W-1:0] K_115 = 25'sd115;
    localparam logic signed [ACC_W-1:0] K_52  = 25'sd52;
    localparam logic signed [ACC_W-1:0] K_RND = 25'sd63;

    logic [SAMPLE_W-1:0]     w_base;
    logic signed [ACC_W-1:0] w_p1;
    logic signed [ACC_W-1:0] w_p2;
    logic signed [ACC_W-1:0] w_acc;
    logic signed [ACC_W-1:0] w_adj;
    logic signed [ACC_W-1:0] w_pred;

    // The sign-extended nibble is shifted and only its low 16 bits survive.
    assign w_base = {{(SAMPLE_W-4){i_nibble[3]}}, i_nibble} << i_hdr.shift;

    assign w_p1 = {{(ACC_W-SAMPLE_W){i_prev_one[SAMPLE_W-1]}}, i_prev_one};
    assign w_p2 = {{(ACC_W-SAMPLE_W){i_prev_two[SAMPLE_W-1]}}, i_prev_two};

    always_comb begin
        case (i_hdr.filter)
            FILT_ONE: w_acc = w_p1 * K_60;
            FILT_TWO: w_acc = w_p1 * K_122 - w_p2 * K_60;
            FILT_THR: w_acc = w_p1 * K_115 - w_p2 * K_52;
            default:  w_acc = '0;
        endcase
    end

    // Division by 64 truncated toward zero: bias negative values first.
    assign w_adj  = w_acc[ACC_W-1] ? (w_acc + K_RND) : w_acc;
    assign w_pred = w_adj >>> 6;

    // The sum wraps to 16 bits.
    assign o_sample = w_base + w_pred[SAMPLE_W-1:0];

endmodule

// ===== rtl/core/brr_adpcm_block_decoder.sv =====
// ----------------------------------------------------------------------------
// BRR ADPCM block decoder
// Decodes header and data bytes of bit-rate-reduction blocks into samples.
// ----------------------------------------------------------------------------
// Each input item is one byte of a block. A header item latches the shift,
// the filter and the end bit, may clear the two-sample history, completes
// without waiting on the output and produces no result. A data item produces
// two result items, the high nibble first, and uses the single shared sample
// calculator once per nibble, so results flow at one per cycle while the
// output does not stall. An input register holds the byte being decoded and
// an output register holds the finished sample, so the next byte is taken in
// the cycle its predecessor's second sample is produced, even while that
// sample still waits downstream. A data byte is registered at the input and
// its first result then at the output. Each sample is computed from the
// history left by the one before it, keeping the work one sample per cycle.
// ----------------------------------------------------------------------------
module brr_adpcm_block_decoder
    import brr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Byte channel.
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_is_header,
    input  logic [7:0]          i_data_byte,
    input  logic                i_clear_history,
    // Sample channel.
    output logic                o_valid,
    input  logic                i_stall,
    output logic [SAMPLE_W-1:0] o_sample,
    output logic                o_second_of_pair,
    output logic                o_block_last,
    output logic                o_end_flag
);

    // Input register.
    logic r_in_valid, n_in_valid;
    logic r_in_hdr;
    logic r_in_clr;
    logic [7:0] r_in_byte;
    logic r_phase, n_phase;

    // Decoder state.
    t_brr_hdr r_hdr, n_hdr;
    logic [SAMPLE_W-1:0] r_prev_one, n_prev_one;
    logic [SAMPLE_W-1:0] r_prev_two, n_prev_two;
    logic [2:0] r_count, n_count;

    // Output register.
    logic r_out_valid, n_out_valid;
    logic [SAMPLE_W-1:0] r_sample;
    logic r_second;
    logic r_last;
    logic r_end;

    logic w_out_ready;
    logic w_hdr_step;
    logic w_load;
    logic w_done;
    logic w_accept;
    logic [3:0] w_nibble;
    logic [SAMPLE_W-1:0] w_sample;

    // The output register can take a sample when empty or being drained.
    assign w_out_ready = !r_out_valid || !i_stall;
    assign w_hdr_step  = r_in_valid && r_in_hdr;
    assign w_load      = r_in_valid && !r_in_hdr && w_out_ready;
    // The held item is finished after a header step or its second sample.
    assign w_done      = w_hdr_step || (w_load && r_phase);
    assign o_stall     = r_in_valid && !w_done;
    assign w_accept    = i_valid && !o_stall;

    assign w_nibble = r_phase ? r_in_byte[3:0] : r_in_byte[7:4];

    brr_sample_calc u_calc (
        .i_nibble   (w_nibble),
        .i_hdr      (r_hdr),
        .i_prev_one (r_prev_one),
        .i_prev_two (r_prev_two),
        .o_sample   (w_sample)
    );

    always_comb begin
        n_in_valid  = r_in_valid;
        n_phase     = r_phase;
        n_hdr       = r_hdr;
        n_prev_one  = r_prev_one;
        n_prev_two  = r_prev_two;
        n_count     = r_count;
        n_out_valid = r_out_valid;

        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_done) begin
            n_in_valid = 1'b0;
        end

        if (w_hdr_step) begin
            n_hdr.shift   = r_in_byte[7:4];
            n_hdr.filter  = r_in_byte[3:2];
            n_hdr.end_bit = r_in_byte[0];
            n_count       = 3'd0;
            if (r_in_clr) begin
                n_prev_one = '0;
                n_prev_two = '0;
            end
        end

        if (w_load) begin
            n_phase    = !r_phase;
            n_prev_two = r_prev_one;
            n_prev_one = w_sample;
            if (r_phase) begin
                n_count = r_count + 3'd1;
            end
        end

        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_phase     <= 1'b0;
            r_hdr       <= '0;
            r_prev_one  <= '0;
            r_prev_two  <= '0;
            r_count     <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_phase     <= n_phase;
            r_hdr       <= n_hdr;
            r_prev_one  <= n_prev_one;
            r_prev_two  <= n_prev_two;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_hdr  <= i_is_header;
            r_in_clr  <= i_clear_history;
            r_in_byte <= i_data_byte;
        end
        if (w_load) begin
            r_sample <= w_sample;
            r_second <= r_phase;
            r_last   <= r_phase && (r_count == 3'd7);
            r_end    <= r_hdr.end_bit;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_sample         = r_sample;
    assign o_second_of_pair = r_second;
    assign o_block_last     = r_last;
    assign o_end_flag       = r_end;

    // The second half of a byte is only ever pending for a held data item.
    a_phase_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (r_in_valid && !r_in_hdr))
        else $error("phase set without a data item held");

    // A first-half sample is always followed by the second half of that byte.
    a_phase_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !r_phase) |=> (r_phase && r_in_valid))
        else $error("second nibble lost after first sample");

    // The block end marker only rides on the second sample of a byte.
    a_last_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_block_last) |-> o_second_of_pair)
        else $error("block_last on a first sample");

    // A new item is only taken when the held one is gone or finishing.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (!r_in_valid || w_done))
        else $error("input register overrun");

endmodule
